// File: rtl/core/mls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mls_pkg
// Shared widths, codes, reset values and types of the mouse-look smoother.
// ----------------------------------------------------------------------------
package mls_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned MoveW    = 16;
  localparam int unsigned AngW     = 32;
  localparam int unsigned PitchW   = 25;
  localparam int unsigned SensW    = 16;
  localparam int unsigned SmoothW  = 17;
  localparam int unsigned SumWidthDef = 24;

  // bit-serial multiplier: signed multiplicand, unsigned multiplier
  localparam int unsigned MulAW    = 33;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned ProdW    = MulAW + MulBW;

  // APB
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [CmdW-1:0] CmdDelta = 3'd0;
  localparam logic [CmdW-1:0] CmdTick  = 3'd1;
  localparam logic [CmdW-1:0] CmdBegin = 3'd2;
  localparam logic [CmdW-1:0] CmdEnd   = 3'd3;
  localparam logic [CmdW-1:0] CmdClear = 3'd4;

  localparam logic [2:0] RegEnable = 3'd0;
  localparam logic [2:0] RegSens   = 3'd1;
  localparam logic [2:0] RegInvert = 3'd2;
  localparam logic [2:0] RegUpper  = 3'd3;
  localparam logic [2:0] RegLower  = 3'd4;
  localparam logic [2:0] RegSmooth = 3'd5;

  localparam logic [SensW-1:0]          SensReset   = 16'd4096;
  localparam logic [SensW-1:0]          SensFloor   = 16'd41;
  localparam logic signed [PitchW-1:0]  UpperReset  = 25'sd5767168;
  localparam logic signed [PitchW-1:0]  LowerReset  = -25'sd5767168;
  localparam logic [SmoothW-1:0]        SmoothOne   = 17'h10000;

  typedef struct packed {
    logic load;
    logic step;
  } mul_ctrl_t;

  // product * 16 saturated to 32 bits; fits when bits [49:27] agree
  function automatic logic [AngW-1:0] sat_target(input logic [ProdW-1:0] p);
    logic same;
    same = (&p[ProdW-1:27]) | ~(|p[ProdW-1:27]);
    if (same) begin
      sat_target = {p[27:0], 4'b0000};
    end else if (p[ProdW-1]) begin
      sat_target = {1'b1, {(AngW-1){1'b0}}};
    end else begin
      sat_target = {1'b0, {(AngW-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mls_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mls_in_if
// Input item channel: command and mouse counts.
// ----------------------------------------------------------------------------
interface mls_in_if;
  logic                                valid;
  logic                                ready;
  logic [mls_pkg::CmdW-1:0]            cmd;
  logic signed [mls_pkg::MoveW-1:0]    move_x;
  logic signed [mls_pkg::MoveW-1:0]    move_y;

  modport source (output valid, cmd, move_x, move_y, input ready);
  modport sink   (input valid, cmd, move_x, move_y, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mls_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mls_out_if
// Result item channel: smoothed steps, totals and look flag.
// ----------------------------------------------------------------------------
interface mls_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mls_pkg::AngW-1:0]     yaw_step;
  logic signed [mls_pkg::AngW-1:0]     pitch_step;
  logic signed [mls_pkg::AngW-1:0]     yaw_total;
  logic signed [mls_pkg::PitchW-1:0]   pitch_total;
  logic                                is_looking;

  modport source (output valid, yaw_step, pitch_step, yaw_total, pitch_total,
                  is_looking, input ready);
  modport sink   (input valid, yaw_step, pitch_step, yaw_total, pitch_total,
                  is_looking, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mls_mul_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mls_mul_lane
// Bit-serial multiplier: one multiplier bit per cycle while step is set,
// product bits shifted out of the accumulator into a low shift register.
// ----------------------------------------------------------------------------
module mls_mul_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mls_pkg::mul_ctrl_t                   ctrl_i,
  input  logic signed [mls_pkg::MulAW-1:0]     mcand_i,
  input  logic [mls_pkg::MulBW-1:0]            mplier_i,
  output logic signed [mls_pkg::ProdW-1:0]     prod_o
);

  logic signed [mls_pkg::MulAW-1:0] mcand_q, mcand_d;
  logic [mls_pkg::MulBW-1:0]        mplier_q, mplier_d;
  logic signed [mls_pkg::MulAW-1:0] acc_q, acc_d;
  logic [mls_pkg::MulBW-1:0]        lo_q, lo_d;
  logic signed [mls_pkg::MulAW:0]   sum;

  always_comb begin
    sum      = {acc_q[mls_pkg::MulAW-1], acc_q}
             + (mplier_q[0] ? {mcand_q[mls_pkg::MulAW-1], mcand_q}
                            : {(mls_pkg::MulAW+1){1'b0}});
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    lo_d     = lo_q;
    if (ctrl_i.load) begin
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      acc_d    = '0;
      lo_d     = '0;
    end else if (ctrl_i.step) begin
      mplier_d = {1'b0, mplier_q[mls_pkg::MulBW-1:1]};
      acc_d    = sum[mls_pkg::MulAW:1];
      lo_d     = {sum[0], lo_q[mls_pkg::MulBW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      lo_q  <= '0;
    end else begin
      acc_q <= acc_d;
      lo_q  <= lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign prod_o = {acc_q, lo_q};

endmodule
`default_nettype wire

// File: rtl/core/mouse_look_smoother_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_look_smoother_top
// Mouse-look integrator: saturating delta sums, sensitivity scaling, one-pole
// smoothing per axis, wrapping yaw total and clamped pitch total.
// ----------------------------------------------------------------------------
// Every input item returns one result item. Delta, begin look, end look,
// reset accumulated, unknown commands and ticks outside look mode go from
// idle straight to the result hand-off. A tick in look mode runs both axes
// in parallel through a bit-serial multiplier lane each: load, 17 steps
// for the sensitivity scaling, saturation, 17 steps for the smoothing
// product, rounding, yaw add, pitch add, clamp and hand-off. A result
// register holds one finished item, so the next item is
// taken while that result waits. Registers are written through APB at
// byte address 4*i: enable, sensitivity, invert, pitch upper, pitch lower,
// smoothing factor.
// ----------------------------------------------------------------------------
module mouse_look_smoother_top #(
  parameter int unsigned SUM_WIDTH = mls_pkg::SumWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mls_in_if.sink                        in_i,
  mls_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mls_pkg::AddrW-1:0]     paddr,
  input  logic [mls_pkg::DataW-1:0]     pwdata,
  output logic [mls_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  localparam int unsigned SumW1 = SUM_WIDTH + 1;
  localparam int unsigned CntW  = $clog2(mls_pkg::MulBW);
  localparam int unsigned AW    = mls_pkg::AngW;
  localparam int unsigned PW    = mls_pkg::PitchW;
  localparam int unsigned MW    = mls_pkg::MulAW;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StMulT  = 8'b0000_0010,
    StSat   = 8'b0000_0100,
    StMulS  = 8'b0000_1000,
    StFin   = 8'b0001_0000,
    StAcc   = 8'b0010_0000,
    StClamp = 8'b0100_0000,
    StEmit  = 8'b1000_0000
  } state_e;

  // configuration
  logic                          cfg_enable_q;
  logic [mls_pkg::SensW-1:0]     cfg_sens_q;
  logic                          cfg_invert_q;
  logic signed [PW-1:0]          cfg_upper_q;
  logic signed [PW-1:0]          cfg_lower_q;
  logic [mls_pkg::SmoothW-1:0]   cfg_smooth_q;
  logic                          cfg_wr;

  // state
  state_e                        state_q, state_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          looking_q, looking_d;
  logic signed [SUM_WIDTH-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic signed [AW-1:0]          yaw_sm_q, yaw_sm_d, pitch_sm_q, pitch_sm_d;
  logic signed [AW-1:0]          yaw_acc_q, yaw_acc_d;
  logic signed [PW-1:0]          pitch_acc_q, pitch_acc_d;
  logic signed [AW-1:0]          tgt_y_q, tgt_y_d, tgt_p_q, tgt_p_d;
  logic signed [AW:0]            psum_q, psum_d;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic                          out_load;
  logic signed [AW-1:0]          o_yaw_step_q, o_pitch_step_q, o_yaw_total_q;
  logic signed [PW-1:0]          o_pitch_total_q;
  logic                          o_looking_q;

  // lanes
  mls_pkg::mul_ctrl_t            mul_ctrl;
  logic signed [MW-1:0]          mcand_y, mcand_p;
  logic [mls_pkg::MulBW-1:0]     mplier;
  logic signed [mls_pkg::ProdW-1:0] prod_y, prod_p;

  // misc
  logic                          in_acc;
  logic                          active;
  logic [mls_pkg::SensW-1:0]     sens_eff;
  logic [mls_pkg::SmoothW-1:0]   s_eff;
  logic signed [AW-1:0]          sat_y, sat_p;
  logic signed [SumW1-1:0]       wide_x, wide_y;
  logic signed [SUM_WIDTH-1:0]   new_x, new_y;
  logic signed [SUM_WIDTH-1:0]   sum_max, sum_min;
  logic signed [MW-1:0]          sx_ext, sy_ext;
  logic signed [AW:0]            lim_hi, up_ext, lo_ext;
  logic                          last_step;

  // --------------------------------------------------------------------------
  // APB registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_enable_q <= 1'b1;
      cfg_sens_q   <= mls_pkg::SensReset;
      cfg_invert_q <= 1'b0;
      cfg_upper_q  <= mls_pkg::UpperReset;
      cfg_lower_q  <= mls_pkg::LowerReset;
      cfg_smooth_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        mls_pkg::RegEnable: cfg_enable_q <= pwdata[0];
        mls_pkg::RegSens:   cfg_sens_q   <= pwdata[mls_pkg::SensW-1:0];
        mls_pkg::RegInvert: cfg_invert_q <= pwdata[0];
        mls_pkg::RegUpper:  cfg_upper_q  <= pwdata[PW-1:0];
        mls_pkg::RegLower:  cfg_lower_q  <= pwdata[PW-1:0];
        mls_pkg::RegSmooth: cfg_smooth_q <= pwdata[mls_pkg::SmoothW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      mls_pkg::RegEnable: prdata = {{(mls_pkg::DataW-1){1'b0}}, cfg_enable_q};
      mls_pkg::RegSens:   prdata = {{(mls_pkg::DataW-mls_pkg::SensW){1'b0}}, cfg_sens_q};
      mls_pkg::RegInvert: prdata = {{(mls_pkg::DataW-1){1'b0}}, cfg_invert_q};
      mls_pkg::RegUpper:  prdata = {{(mls_pkg::DataW-PW){cfg_upper_q[PW-1]}}, cfg_upper_q};
      mls_pkg::RegLower:  prdata = {{(mls_pkg::DataW-PW){cfg_lower_q[PW-1]}}, cfg_lower_q};
      mls_pkg::RegSmooth: prdata = {{(mls_pkg::DataW-mls_pkg::SmoothW){1'b0}}, cfg_smooth_q};
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Multiplier lanes
  // --------------------------------------------------------------------------
  mls_mul_lane u_lane_yaw (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mul_ctrl),
    .mcand_i  (mcand_y),
    .mplier_i (mplier),
    .prod_o   (prod_y)
  );

  mls_mul_lane u_lane_pitch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mul_ctrl),
    .mcand_i  (mcand_p),
    .mplier_i (mplier),
    .prod_o   (prod_p)
  );

  // --------------------------------------------------------------------------
  // Datapath and sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    in_acc    = in_i.valid && (state_q == StIdle);
    active    = cfg_enable_q && looking_q;
    sens_eff  = (cfg_sens_q < mls_pkg::SensFloor) ? mls_pkg::SensFloor : cfg_sens_q;
    s_eff     = (cfg_smooth_q > mls_pkg::SmoothOne) ? mls_pkg::SmoothOne : cfg_smooth_q;
    sat_y     = mls_pkg::sat_target(prod_y);
    sat_p     = mls_pkg::sat_target(prod_p);
    last_step = (cnt_q == CntW'(mls_pkg::MulBW - 1));

    sum_max = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    sum_min = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    wide_x  = {sum_x_q[SUM_WIDTH-1], sum_x_q}
            + {{(SumW1-mls_pkg::MoveW){in_i.move_x[mls_pkg::MoveW-1]}}, in_i.move_x};
    wide_y  = {sum_y_q[SUM_WIDTH-1], sum_y_q}
            + {{(SumW1-mls_pkg::MoveW){in_i.move_y[mls_pkg::MoveW-1]}}, in_i.move_y};
    new_x   = (wide_x[SUM_WIDTH] != wide_x[SUM_WIDTH-1])
            ? (wide_x[SUM_WIDTH] ? sum_min : sum_max) : wide_x[SUM_WIDTH-1:0];
    new_y   = (wide_y[SUM_WIDTH] != wide_y[SUM_WIDTH-1])
            ? (wide_y[SUM_WIDTH] ? sum_min : sum_max) : wide_y[SUM_WIDTH-1:0];
    sx_ext  = {{(MW-SUM_WIDTH){sum_x_q[SUM_WIDTH-1]}}, sum_x_q};
    sy_ext  = {{(MW-SUM_WIDTH){sum_y_q[SUM_WIDTH-1]}}, sum_y_q};

    up_ext  = {{(AW+1-PW){cfg_upper_q[PW-1]}}, cfg_upper_q};
    lo_ext  = {{(AW+1-PW){cfg_lower_q[PW-1]}}, cfg_lower_q};
    lim_hi  = (psum_q > up_ext) ? up_ext : psum_q;

    state_d     = state_q;
    cnt_d       = cnt_q;
    looking_d   = looking_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    yaw_sm_d    = yaw_sm_q;
    pitch_sm_d  = pitch_sm_q;
    yaw_acc_d   = yaw_acc_q;
    pitch_acc_d = pitch_acc_q;
    tgt_y_d     = tgt_y_q;
    tgt_p_d     = tgt_p_q;
    psum_d      = psum_q;
    out_load    = 1'b0;
    mul_ctrl    = '0;
    mcand_y     = sx_ext;
    mcand_p     = cfg_invert_q ? -sy_ext : sy_ext;
    mplier      = {1'b0, sens_eff};

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StEmit;
          case (in_i.cmd)
            mls_pkg::CmdDelta: begin
              if (active) begin
                sum_x_d = new_x;
                sum_y_d = new_y;
              end
            end
            mls_pkg::CmdTick: begin
              sum_x_d = '0;
              sum_y_d = '0;
              if (active) begin
                mul_ctrl.load = 1'b1;
                cnt_d         = '0;
                state_d       = StMulT;
              end else begin
                yaw_sm_d   = '0;
                pitch_sm_d = '0;
              end
            end
            mls_pkg::CmdBegin: begin
              if (cfg_enable_q) begin
                looking_d = 1'b1;
              end
            end
            mls_pkg::CmdEnd: begin
              looking_d = 1'b0;
              sum_x_d   = '0;
              sum_y_d   = '0;
            end
            mls_pkg::CmdClear: begin
              yaw_acc_d   = '0;
              pitch_acc_d = '0;
            end
            default: ;
          endcase
        end
      end
      StMulT, StMulS: begin
        mul_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (last_step) begin
          state_d = (state_q == StMulT) ? StSat : StFin;
        end
      end
      StSat: begin
        // smoothed = t + round((old - t) * s / 65536)
        tgt_y_d       = sat_y;
        tgt_p_d       = sat_p;
        mcand_y       = {yaw_sm_q[AW-1], yaw_sm_q} - {sat_y[AW-1], sat_y};
        mcand_p       = {pitch_sm_q[AW-1], pitch_sm_q} - {sat_p[AW-1], sat_p};
        mplier        = s_eff;
        mul_ctrl.load = 1'b1;
        cnt_d         = '0;
        state_d       = StMulS;
      end
      StFin: begin
        yaw_sm_d   = tgt_y_q + prod_y[AW+15:16] + {{(AW-1){1'b0}}, prod_y[15]};
        pitch_sm_d = tgt_p_q + prod_p[AW+15:16] + {{(AW-1){1'b0}}, prod_p[15]};
        state_d    = StAcc;
      end
      StAcc: begin
        yaw_acc_d = yaw_acc_q + yaw_sm_q;
        psum_d    = {{(AW+1-PW){pitch_acc_q[PW-1]}}, pitch_acc_q}
                  + {pitch_sm_q[AW-1], pitch_sm_q};
        state_d   = StClamp;
      end
      StClamp: begin
        pitch_acc_d = (lim_hi < lo_ext) ? cfg_lower_q : lim_hi[PW-1:0];
        state_d     = StEmit;
      end
      StEmit: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    out_valid_d = (out_valid_q && !out_o.ready) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      looking_q   <= 1'b0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      yaw_sm_q    <= '0;
      pitch_sm_q  <= '0;
      yaw_acc_q   <= '0;
      pitch_acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      looking_q   <= looking_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      yaw_sm_q    <= yaw_sm_d;
      pitch_sm_q  <= pitch_sm_d;
      yaw_acc_q   <= yaw_acc_d;
      pitch_acc_q <= pitch_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_y_q <= tgt_y_d;
    tgt_p_q <= tgt_p_d;
    psum_q  <= psum_d;
    if (out_load) begin
      o_yaw_step_q    <= yaw_sm_q;
      o_pitch_step_q  <= pitch_sm_q;
      o_yaw_total_q   <= yaw_acc_q;
      o_pitch_total_q <= pitch_acc_q;
      o_looking_q     <= looking_q;
    end
  end

  assign in_i.ready        = (state_q == StIdle);
  assign out_o.valid       = out_valid_q;
  assign out_o.yaw_step    = o_yaw_step_q;
  assign out_o.pitch_step  = o_pitch_step_q;
  assign out_o.yaw_total   = o_yaw_total_q;
  assign out_o.pitch_total = o_pitch_total_q;
  assign out_o.is_looking  = o_looking_q;

endmodule
`default_nettype wire
